FILE: rtl/core/sbtf_pkg.sv
// Shared types and constants for the sprite blitter with color key and flip.
package sbtf_pkg;

   localparam int unsigned DefaultSliceWidth = 256;
   localparam int unsigned DefaultSliceRows  = 64;

   localparam int unsigned PixelW  = 16;
   localparam int unsigned AddrW   = 14;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 9;
   localparam int unsigned CountW  = 8;

   localparam logic [PixelW-1:0] FlashWhite = 16'hFFFF;

   typedef enum logic [CsrIdxW-1:0] {
      CsrPartLeft   = 3'd0,
      CsrPartTop    = 3'd1,
      CsrPartRight  = 3'd2,
      CsrPartBottom = 3'd3,
      CsrDestX      = 3'd4,
      CsrDestY      = 3'd5,
      CsrMirror     = 3'd6,
      CsrFlash      = 3'd7
   } csr_index_type;

endpackage

FILE: rtl/core/sprite_blit_transparent_flip.sv
// Sprite blitter top level: color key, mirror, flash and slice-bounds check.
//
// One slice-buffer write request leaves for every sprite pixel request taken,
// in order. The block sustains one request per clock while rsp_stall is low:
// a capture stage holds the pixel together with the column and row
// position it was taken at, and the result stage forms the target column and
// row, the range flag, the color and the address (one multiply by the slice
// width plus the column). Two request slots sit between the sides, so a new
// request is still taken while a finished result waits; req_stall rises only
// when both slots are full and rsp_stall holds the result. Pixel value zero is
// transparent and gives a request with write_enable low and color zero; targets
// outside the slice raise out_of_range, drop the write and give address zero.
// The pixel that closes the part carries last and returns both position
// counters to zero. Configure only while no request is in flight; the counters
// are not cleared by a configuration write.
module sprite_blit_transparent_flip #(
   parameter int unsigned SLICE_COLS = sbtf_pkg::DefaultSliceWidth,
   parameter int unsigned SLICE_ROWS = sbtf_pkg::DefaultSliceRows
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_enable,
   input  logic [sbtf_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sbtf_pkg::CsrDataW-1:0] csr_data,
   // pixel requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sbtf_pkg::PixelW-1:0]   req_pixel,
   // slice-buffer write requests
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_enable,
   output logic [sbtf_pkg::AddrW-1:0]    rsp_write_address,
   output logic [sbtf_pkg::PixelW-1:0]   rsp_write_color,
   output logic                          rsp_out_of_range,
   output logic                          rsp_last
);

   localparam int unsigned CW    = sbtf_pkg::CountW;
   localparam int unsigned PosW  = 12;
   localparam int unsigned ProdW = $clog2(SLICE_ROWS * SLICE_COLS) + sbtf_pkg::AddrW;

   // configuration registers
   logic [CW-1:0] part_left_ff, part_top_ff, part_right_ff, part_bottom_ff;
   logic [8:0]    dest_x_ff, dest_y_ff;
   logic          mirror_ff, flash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_left_ff   <= '0;
         part_top_ff    <= '0;
         part_right_ff  <= '0;
         part_bottom_ff <= '0;
         dest_x_ff      <= '0;
         dest_y_ff      <= '0;
         mirror_ff      <= 1'b0;
         flash_ff       <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (sbtf_pkg::csr_index_type'(csr_index))
            sbtf_pkg::CsrPartLeft:   part_left_ff   <= csr_data[CW-1:0];
            sbtf_pkg::CsrPartTop:    part_top_ff    <= csr_data[CW-1:0];
            sbtf_pkg::CsrPartRight:  part_right_ff  <= csr_data[CW-1:0];
            sbtf_pkg::CsrPartBottom: part_bottom_ff <= csr_data[CW-1:0];
            sbtf_pkg::CsrDestX:      dest_x_ff      <= csr_data;
            sbtf_pkg::CsrDestY:      dest_y_ff      <= csr_data;
            sbtf_pkg::CsrMirror:     mirror_ff      <= csr_data[0];
            sbtf_pkg::CsrFlash:      flash_ff       <= csr_data[0];
         endcase
      end
   end

   // part extent minus one, 8-bit wrapped
   logic [CW-1:0] wdiff, hdiff;
   assign wdiff = part_right_ff - part_left_ff;
   assign hdiff = part_bottom_ff - part_top_ff;

   // handshake: the result slot frees when empty or taken downstream
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_ready, s1_move, req_take;

   assign s2_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_ready;
   assign req_stall = s1_valid_ff && !s2_ready;
   assign req_take  = req_valid && !req_stall;

   // position counters advance on every request taken
   logic [CW-1:0] col_count_ff, col_count_in, row_count_ff, row_count_in;
   logic          row_end, part_end;

   assign row_end  = col_count_ff >= wdiff;
   assign part_end = row_end && (row_count_ff >= hdiff);

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_take) begin
         if (part_end) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (row_end) begin
            col_count_in = '0;
            row_count_in = row_count_ff + 1'b1;
         end else begin
            col_count_in = col_count_ff + 1'b1;
         end
      end
   end

   // capture stage: pixel plus the position it was taken at
   logic [sbtf_pkg::PixelW-1:0] s1_pixel_ff;
   logic [CW-1:0]               s1_col_ff, s1_row_ff;
   logic                        s1_last_ff;

   assign s1_valid_in = req_take || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= req_pixel;
         s1_col_ff   <= col_count_ff;
         s1_row_ff   <= row_count_ff;
         s1_last_ff  <= part_end;
      end
   end

   // target column and row in the slice, signed
   logic signed [PosW-1:0] col_off, tc, tr;
   logic                   oor, opaque, we;
   logic [ProdW-1:0]       addr_full;

   always_comb begin
      if (mirror_ff) begin
         col_off = $signed({4'b0, wdiff}) - $signed({4'b0, s1_col_ff});
      end else begin
         col_off = $signed({4'b0, s1_col_ff});
      end
      tc = $signed({{3{dest_x_ff[8]}}, dest_x_ff}) + $signed({4'b0, part_left_ff}) + col_off;
      tr = $signed({{3{dest_y_ff[8]}}, dest_y_ff}) + $signed({4'b0, part_top_ff})
         + $signed({4'b0, s1_row_ff});
      oor = tc[PosW-1] || (tc >= $signed(PosW'(SLICE_COLS)))
         || tr[PosW-1] || (tr >= $signed(PosW'(SLICE_ROWS)));
      opaque = s1_pixel_ff != '0;
      we     = opaque && !oor;
      addr_full = ProdW'(tr[9:0]) * ProdW'(SLICE_COLS) + ProdW'(tc[10:0]);
   end

   // result stage
   logic                        wen_ff;
   logic [sbtf_pkg::AddrW-1:0]  addr_ff;
   logic [sbtf_pkg::PixelW-1:0] color_ff;
   logic                        oor_ff, last_ff;

   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         wen_ff   <= we;
         addr_ff  <= oor ? '0 : addr_full[sbtf_pkg::AddrW-1:0];
         color_ff <= !we ? '0 : (flash_ff ? sbtf_pkg::FlashWhite : s1_pixel_ff);
         oor_ff   <= oor;
         last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = wen_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_color   = color_ff;
   assign rsp_out_of_range  = oor_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/core/sbtf_checker.sv
// Port-level assertions for the sprite blitter, bound to its top level.
module sbtf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_write_enable,
   input logic [sbtf_pkg::AddrW-1:0]    rsp_write_address,
   input logic [sbtf_pkg::PixelW-1:0]   rsp_write_color,
   input logic                          rsp_out_of_range
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // back-pressure only when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with free result slot");

   a_we_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> !rsp_out_of_range)
      else $error("write enabled outside the slice");

   a_oor_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_write_address == '0)
      else $error("nonzero address for out-of-range target");

   a_no_write_color: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_write_color == '0)
      else $error("color given for suppressed write");

endmodule

bind sprite_blit_transparent_flip sbtf_checker u_sbtf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_write_enable  (rsp_write_enable),
   .rsp_write_address (rsp_write_address),
   .rsp_write_color   (rsp_write_color),
   .rsp_out_of_range  (rsp_out_of_range)
);
